// ===== rtl/pcc_pkg.sv =====
// shared types and state codes for the polygon convexity checker
package pcc_pkg;

	// turn direction of one vertex triple, collinear counts as positive
	typedef struct packed {
		logic pos;
		logic neg;
	} turn_t;

	localparam int unsigned PHASE_W = 2;

	// number of vertices held so far, saturating at two
	localparam logic [PHASE_W-1:0] PH_EMPTY = 2'd0;
	localparam logic [PHASE_W-1:0] PH_ONE   = 2'd1;
	localparam logic [PHASE_W-1:0] PH_RUN   = 2'd2;

endpackage

// ===== rtl/polygon_convexity_check.sv =====
// polygon convexity check over a stream of vertices, one result per polygon
//
// channel  dir  fields
// s_*      in   tdata: x_coord, y_coord; tlast: final_vertex
// m_*      out  tdata: convex (bit 0)
//
// a vertex is taken into an input register and processed in the next cycle unless it must wait (below);
// one vertex per cycle is sustained, the final vertex included unless it must wait
// the verdict is loaded into the output register at the edge that ends the
// processing cycle of its final vertex
// a final vertex waits in the input register only while the output register is full
// and not being taken; other vertices never wait
// arst_n clears the phase, turn flags and valid bits; no clearing pass is needed
module polygon_convexity_check #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      s_tvalid,
	output logic                                      s_tready,
	input  logic [((2 * COORD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // x_coord, y_coord, zero fill
	input  logic                                      s_tlast,  // final_vertex
	output logic                                      m_tvalid,
	input  logic                                      m_tready,
	output logic [7:0]                                m_tdata   // convex, zero fill
);

	// input register
	logic                          valid_s1;
	logic                          last_s1;
	logic signed [COORD_WIDTH-1:0] x_s1, y_s1;

	// polygon state
	logic signed [COORD_WIDTH-1:0] first_x_q, first_y_q, second_x_q, second_y_q;
	logic signed [COORD_WIDTH-1:0] older_x_q, older_y_q, newer_x_q, newer_y_q;
	logic [pcc_pkg::PHASE_W-1:0]   phase_q;
	logic                          saw_pos_q, saw_neg_q;

	// output register
	logic                          out_valid_q;
	logic                          convex_q;

	logic                          go;
	logic signed [COORD_WIDTH-1:0] second_x_eff, second_y_eff;
	pcc_pkg::turn_t                turn_run, turn_wrap1, turn_wrap2;
	logic                          pos_nx, neg_nx;
	logic                          convex_nx;

	assign go       = valid_s1 && (!last_s1 || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || go;

	// on a two-vertex polygon the second vertex is the one arriving now
	assign second_x_eff = (phase_q == pcc_pkg::PH_ONE) ? x_s1 : second_x_q;
	assign second_y_eff = (phase_q == pcc_pkg::PH_ONE) ? y_s1 : second_y_q;

	pcc_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_run (
		.ax(older_x_q), .ay(older_y_q), .bx(newer_x_q), .by(newer_y_q),
		.cx(x_s1), .cy(y_s1), .turn(turn_run)
	);

	pcc_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_wrap1 (
		.ax(newer_x_q), .ay(newer_y_q), .bx(x_s1), .by(y_s1),
		.cx(first_x_q), .cy(first_y_q), .turn(turn_wrap1)
	);

	pcc_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_wrap2 (
		.ax(x_s1), .ay(y_s1), .bx(first_x_q), .by(first_y_q),
		.cx(second_x_eff), .cy(second_y_eff), .turn(turn_wrap2)
	);

	always_comb begin
		pos_nx = saw_pos_q;
		neg_nx = saw_neg_q;
		if (phase_q != pcc_pkg::PH_EMPTY && phase_q != pcc_pkg::PH_ONE) begin
			pos_nx = pos_nx | turn_run.pos;
			neg_nx = neg_nx | turn_run.neg;
		end
		if (phase_q == pcc_pkg::PH_EMPTY) begin
			pos_nx = 1'b1;
		end else begin
			pos_nx = pos_nx | turn_wrap1.pos | turn_wrap2.pos;
			neg_nx = neg_nx | turn_wrap1.neg | turn_wrap2.neg;
		end
		convex_nx = !(pos_nx && neg_nx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			x_s1    <= s_tdata[COORD_WIDTH-1:0];
			y_s1    <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= pcc_pkg::PH_EMPTY;
			saw_pos_q <= 1'b0;
			saw_neg_q <= 1'b0;
		end else if (go) begin
			if (last_s1) begin
				phase_q   <= pcc_pkg::PH_EMPTY;
				saw_pos_q <= 1'b0;
				saw_neg_q <= 1'b0;
			end else begin
				unique case (phase_q)
					pcc_pkg::PH_EMPTY: phase_q <= pcc_pkg::PH_ONE;
					pcc_pkg::PH_ONE:   phase_q <= pcc_pkg::PH_RUN;
					default: begin
						saw_pos_q <= saw_pos_q | turn_run.pos;
						saw_neg_q <= saw_neg_q | turn_run.neg;
					end
				endcase
			end
		end
	end

	// vertex history, only read after being written within the polygon
	always_ff @(posedge clk) begin
		if (go) begin
			unique case (phase_q)
				pcc_pkg::PH_EMPTY: begin
					first_x_q <= x_s1;
					first_y_q <= y_s1;
				end
				pcc_pkg::PH_ONE: begin
					second_x_q <= x_s1;
					second_y_q <= y_s1;
				end
				default: begin
				end
			endcase
			older_x_q <= newer_x_q;
			older_y_q <= newer_y_q;
			newer_x_q <= x_s1;
			newer_y_q <= y_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && last_s1) begin
			convex_q <= convex_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, convex_q};

endmodule

// ===== rtl/pcc_cross.sv =====
// exact turn direction of a vertex triple from the sign of its cross product
module pcc_cross #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	input  logic signed [COORD_WIDTH-1:0] cx,
	input  logic signed [COORD_WIDTH-1:0] cy,
	output pcc_pkg::turn_t                turn
);

	localparam int unsigned DW = COORD_WIDTH + 1;
	localparam int unsigned PW = 2 * COORD_WIDTH + 2;
	localparam int unsigned CW = 2 * COORD_WIDTH + 3;

	logic signed [DW-1:0] ux, uy, vx, vy;
	logic signed [PW-1:0] prod_p, prod_q;
	logic signed [CW-1:0] cross_v;

	// edge vectors b - a and c - a, one bit wider than the coordinates
	assign ux = $signed({bx[COORD_WIDTH-1], bx}) - $signed({ax[COORD_WIDTH-1], ax});
	assign uy = $signed({by[COORD_WIDTH-1], by}) - $signed({ay[COORD_WIDTH-1], ay});
	assign vx = $signed({cx[COORD_WIDTH-1], cx}) - $signed({ax[COORD_WIDTH-1], ax});
	assign vy = $signed({cy[COORD_WIDTH-1], cy}) - $signed({ay[COORD_WIDTH-1], ay});

	assign prod_p  = PW'(ux) * PW'(vy);
	assign prod_q  = PW'(uy) * PW'(vx);
	assign cross_v = CW'(prod_p) - CW'(prod_q);

	assign turn.neg = cross_v[CW-1];
	assign turn.pos = ~cross_v[CW-1];

endmodule
